>>> src/sha1s_pkg.sv
// Shared types and constants of the SHA-1 stream hasher.
// No dependencies; used by every module of the block.
package sha1s_pkg;

  localparam logic [31:0] K_R00 = 32'h5A827999;
  localparam logic [31:0] K_R20 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R40 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R60 = 32'hCA62C1D6;

  // Initial chaining value, index 0 is H0.
  localparam logic [4:0][31:0] INIT_CV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LAST_LANE  = 6'd63;
  localparam logic [5:0] LEN_LANE   = 6'd56;  // first lane of the length field
  localparam logic [6:0] LAST_ROUND = 7'd79;

  // One 512-bit block request from front to back; words[0] is the first word.
  typedef struct packed {
    logic [15:0][31:0] words;
    logic              last;   // final block of a message: emit digest after it
  } blk_t;

  typedef enum logic [1:0] {
    F_ACCEPT,
    F_PUSH_FULL,
    F_PAD_A,
    F_PAD_B
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_DONE
  } back_state_e;

endpackage

>>> src/sha1s_front.sv
// Front end: packs message bytes into the block buffer, keeps the bit count
// and generates the padding blocks. Depends on sha1s_pkg.
module sha1s_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_present_i,
  input  logic               end_of_message_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output sha1s_pkg::blk_t    push_blk_o
);
  import sha1s_pkg::*;

  front_state_e          state_q, state_d;
  logic [15:0][3:0][7:0] buf_q;
  logic [63:0]           count_q, count_d;
  logic                  fin_q, fin_d;
  logic                  accept;
  logic                  wr_byte;
  logic [5:0]            pos;
  logic                  fits;
  logic [15:0][3:0][7:0] pad_blk;

  assign pos    = count_q[8:3];
  assign fits   = pos < LEN_LANE;
  assign accept = in_valid_i && (state_q == F_ACCEPT);

  // 0x80 after the last message byte, zeros above it
  always_comb begin
    for (int l = 0; l < 64; l++) begin
      if (6'(l) < pos) begin
        pad_blk[l / 4][3 - (l % 4)] = buf_q[l / 4][3 - (l % 4)];
      end else if (6'(l) == pos) begin
        pad_blk[l / 4][3 - (l % 4)] = PAD_BYTE;
      end else begin
        pad_blk[l / 4][3 - (l % 4)] = 8'h00;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    fin_d        = fin_q;
    wr_byte      = 1'b0;
    push_valid_o = 1'b0;
    push_blk_o   = '{words: '0, last: 1'b0};
    unique case (state_q)
      F_ACCEPT: begin
        if (accept) begin
          fin_d = end_of_message_i;
          if (byte_present_i) begin
            wr_byte = 1'b1;
            count_d = count_q + 64'd8;
            if (pos == LAST_LANE) begin
              state_d = F_PUSH_FULL;
            end else if (end_of_message_i) begin
              state_d = F_PAD_A;
            end
          end else if (end_of_message_i) begin
            state_d = F_PAD_A;
          end
        end
      end
      F_PUSH_FULL: begin
        push_valid_o     = 1'b1;
        push_blk_o.words = buf_q;
        if (push_ready_i) begin
          state_d = fin_q ? F_PAD_A : F_ACCEPT;
        end
      end
      F_PAD_A: begin
        push_valid_o     = 1'b1;
        push_blk_o.words = pad_blk;
        push_blk_o.last  = fits;
        if (fits) begin
          push_blk_o.words[14] = count_q[63:32];
          push_blk_o.words[15] = count_q[31:0];
        end
        if (push_ready_i) begin
          if (fits) begin
            count_d = '0;
            state_d = F_ACCEPT;
          end else begin
            state_d = F_PAD_B;
          end
        end
      end
      F_PAD_B: begin
        push_valid_o         = 1'b1;
        push_blk_o.last      = 1'b1;
        push_blk_o.words[14] = count_q[63:32];
        push_blk_o.words[15] = count_q[31:0];
        if (push_ready_i) begin
          count_d = '0;
          state_d = F_ACCEPT;
        end
      end
      default: state_d = F_ACCEPT;
    endcase
  end

  assign in_stall_o = (state_q != F_ACCEPT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_ACCEPT;
      count_q <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_byte) begin
      buf_q[pos[5:2]][2'd3 - pos[1:0]] <= data_byte_i;
    end
  end

endmodule

>>> src/sha1s_queue.sv
// Two-entry block queue between front end and compression engine.
// Depends on sha1s_pkg.
module sha1s_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  sha1s_pkg::blk_t  push_blk_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output sha1s_pkg::blk_t  pop_blk_o
);
  import sha1s_pkg::*;

  blk_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_blk_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_blk_i;
    end
  end

endmodule

>>> src/sha1s_back.sv
// Compression engine: one SHA-1 round per cycle over a 16-word schedule
// window, chaining value update and digest output register. Uses sha1s_pkg.
module sha1s_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             blk_valid_i,
  output logic             blk_pop_o,
  input  sha1s_pkg::blk_t  blk_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [4:0][31:0] digest_o
);
  import sha1s_pkg::*;

  back_state_e       state_q, state_d;
  logic [15:0][31:0] w_q;
  logic [4:0][31:0]  st_q;    // a..e working variables, index 0 is a
  logic [4:0][31:0]  cv_q;
  logic [4:0][31:0]  dig_q;
  logic [4:0][31:0]  sum;
  logic [6:0]        rnd_q;
  logic              last_q;
  logic              out_valid_q;
  logic              load, step, finish, emit;
  logic [31:0]       f, k, wsum, wnew, t;

  always_comb begin
    wsum = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = (rnd_q < 7'd16) ? w_q[0] : {wsum[30:0], wsum[31]};
    if (rnd_q < 7'd20) begin
      f = (st_q[1] & st_q[2]) | (~st_q[1] & st_q[3]);
      k = K_R00;
    end else if (rnd_q < 7'd40) begin
      f = st_q[1] ^ st_q[2] ^ st_q[3];
      k = K_R20;
    end else if (rnd_q < 7'd60) begin
      f = (st_q[1] & st_q[2]) | (st_q[1] & st_q[3]) | (st_q[2] & st_q[3]);
      k = K_R40;
    end else begin
      f = st_q[1] ^ st_q[2] ^ st_q[3];
      k = K_R60;
    end
    t = {st_q[0][26:0], st_q[0][31:27]} + f + st_q[4] + k + wnew;
    for (int i = 0; i < 5; i++) begin
      sum[i] = cv_q[i] + st_q[i];
    end
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    step    = 1'b0;
    finish  = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (blk_valid_i) begin
          load    = 1'b1;
          state_d = B_ROUND;
        end
      end
      B_ROUND: begin
        step = 1'b1;
        if (rnd_q == LAST_ROUND) state_d = B_DONE;
      end
      B_DONE: begin
        // a finished digest waits while the previous one is still held
        if (!(last_q && out_valid_q && out_stall_i)) begin
          finish  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign blk_pop_o   = load;
  assign emit        = finish && last_q;
  assign out_valid_o = out_valid_q;
  assign digest_o    = dig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cv_q        <= INIT_CV;
      out_valid_q <= 1'b0;
      rnd_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load) rnd_q <= '0;
      else if (step) rnd_q <= rnd_q + 7'd1;
      if (finish) cv_q <= last_q ? INIT_CV : sum;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      w_q    <= blk_i.words;
      st_q   <= cv_q;
      last_q <= blk_i.last;
    end else if (step) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= wnew;
      st_q[0] <= t;
      st_q[1] <= st_q[0];
      st_q[2] <= {st_q[1][1:0], st_q[1][31:2]};
      st_q[3] <= st_q[2];
      st_q[4] <= st_q[3];
    end
    if (emit) dig_q <= sum;
  end

endmodule

>>> src/sha1_stream_hasher.sv
// Top level of the SHA-1 stream hasher: front end, block queue and
// compression engine. Depends on sha1s_pkg, sha1s_front, sha1s_queue, sha1s_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one request per item, carrying an
//   optional message byte (byte_present_i) and an end-of-message flag. A
//   request is taken when in_valid_i is high and in_stall_o is low.
//   Output channel (out_valid_o / out_stall_i): one request per message with
//   the five digest words, hash_word_0_o first (big-endian bytes).
// Throughput: bytes go in one per cycle while in_stall_o is low; after the
//   64th byte of a block the input stalls while the block is handed to the
//   two-entry queue. The engine works through each block (load, 80 rounds,
//   chaining add) before loading the next; the single round unit sets the rate.
// End of message: the front end stalls after the end-of-message request
//   until its one or two padding blocks are queued; the digest is registered
//   as the engine finishes the final block, which is behind at most two others.
// Reset: the bit count clears, the chaining value takes the SHA-1 initial
//   value, the queue empties and no digest is pending.
// Receiver stall: a digest holds on the outputs; the engine finishes the
//   next message's final block only once that digest has been taken, and the
//   queue then fills and stalls the input side.
module sha1_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_word_0_o,
  output logic [31:0] hash_word_1_o,
  output logic [31:0] hash_word_2_o,
  output logic [31:0] hash_word_3_o,
  output logic [31:0] hash_word_4_o
);
  import sha1s_pkg::*;

  logic             push_valid, push_ready;
  blk_t             push_blk;
  logic             q_valid, q_pop;
  blk_t             q_blk;
  logic [4:0][31:0] digest;

  sha1s_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_blk_o       (push_blk)
  );

  sha1s_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_blk_i   (push_blk),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_blk_o    (q_blk)
  );

  sha1s_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (q_valid),
    .blk_pop_o   (q_pop),
    .blk_i       (q_blk),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digest_o    (digest)
  );

  assign hash_word_0_o = digest[0];
  assign hash_word_1_o = digest[1];
  assign hash_word_2_o = digest[2];
  assign hash_word_3_o = digest[3];
  assign hash_word_4_o = digest[4];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sha1_stream_hasher: byte-stream SHA-1 with digest output.
// Needs only the RTL; an internal SHA-1 predictor queues one digest per message end.
module testbench;

  // Run control
  localparam int ITEM_TARGET    = 1650;  // counted requests (byte and/or end)
  localparam int GAP_MAX        = 11;
  localparam int RX_HOLD_CYCLES = 1000;  // long receiver hold-off for the fill test
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request taken on either side
  localparam int DRAIN_CYCLES   = 400;   // quiet time after the last digest

  // SHA-1 initial chaining value, H0 first
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Word 0 of a digest sits in bits [31:0]
  typedef logic [4:0][31:0] digest_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i      = 8'h00;
  logic        byte_present_i   = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [31:0] hash_word_0_o;
  logic [31:0] hash_word_1_o;
  logic [31:0] hash_word_2_o;
  logic [31:0] hash_word_3_o;
  logic [31:0] hash_word_4_o;

  // Predictor state: running hash of the message in progress
  logic [31:0] chain_h [5];
  logic [31:0] blk_w [16];
  logic [63:0] msg_bits;

  digest_t expected_digests [$];

  // Knobs shared by the test tasks, the input task and the receiver process
  int tx_gap_max  = GAP_MAX;
  int rx_gap_max  = GAP_MAX;
  int rx_hold_len = 0;       // nonzero: receiver holds off this many cycles, then clears it

  int items_sent   = 0;
  int mismatch_cnt = 0;
  int idle_cycles  = 0;

  // Message lengths that land the pad byte and length field on block edges
  int boundary_lens [15] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 118, 119, 120, 127, 128, 129};

  sha1_stream_hasher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_word_0_o    (hash_word_0_o),
    .hash_word_1_o    (hash_word_1_o),
    .hash_word_2_o    (hash_word_2_o),
    .hash_word_3_o    (hash_word_3_o),
    .hash_word_4_o    (hash_word_4_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // SHA-1 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_clear();
    for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    for (int i = 0; i < 16; i++) blk_w[i] = 32'h0;
    msg_bits = 64'h0;
  endfunction

  // 80 rounds over blk_w, folded into chain_h
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wr;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
        w[r % 16] = wr;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + wr;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Byte lane 0 is the MSB of word 0 (big-endian packing)
  function automatic void put_lane(input int pos, input logic [7:0] val);
    blk_w[pos / 4][(3 - pos % 4) * 8 +: 8] = val;
  endfunction

  // Absorb one accepted request; queue the digest when the message ends
  function automatic void sha1_absorb(input logic [7:0] data, input logic present,
                                      input logic eom);
    int pos;
    logic [63:0] len;
    digest_t dg;
    if (present) begin
      pos = int'(msg_bits[8:3]);
      put_lane(pos, data);
      msg_bits += 64'd8;
      if (pos == 63) sha1_compress();
    end
    if (eom) begin
      len = msg_bits;
      pos = int'(len[8:3]);
      put_lane(pos, 8'h80);
      pos++;
      // no room for the length field: pad out and spill into a second block
      if (pos > 56) begin
        while (pos < 64) begin
          put_lane(pos, 8'h00);
          pos++;
        end
        sha1_compress();
        pos = 0;
      end
      while (pos < 56) begin
        put_lane(pos, 8'h00);
        pos++;
      end
      blk_w[14] = len[63:32];
      blk_w[15] = len[31:0];
      sha1_compress();
      for (int j = 0; j < 5; j++) dg[j] = chain_h[j];
      expected_digests.push_back(dg);
      // next message starts from the initial value with a zero count
      for (int j = 0; j < 5; j++) chain_h[j] = H_INIT[j];
      msg_bits = 64'h0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap and return on the edge it is taken.
  // Valid is left high on return; the next call lowers it only if it idles,
  // so valid never gets two assignments in one step.
  task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_byte_i      <= data;
    byte_present_i   <= present;
    end_of_message_i <= eom;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sha1_absorb(data, present, eom);
    if (present || eom) items_sent++;
  endtask

  // One message of len bytes with random content. Some requests carry no byte
  // (ignored by the block); the end flag rides on the last byte or comes alone.
  task automatic send_message(input int len);
    bit end_with_byte;
    end_with_byte = $urandom_range(1, 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9, 0) == 0)
        send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255, 0)), 1'b1, end_with_byte && (i == len - 1));
    end
    if (len == 0 || !end_with_byte)
      send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
  endtask

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 40) return boundary_lens[$urandom_range(14, 0)];
    if (sel < 85) return $urandom_range(40, 0);
    return $urandom_range(150, 41);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver: per digest a random hold-off of 0..rx_gap_max cycles, then stall
  // low until a request is taken. A hold request from a test overrides it.
  initial begin : digest_receiver
    int w;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
        out_stall_i <= 1'b0;
      end else begin
        w = $urandom_range(rx_gap_max, 0);
        if (w > 0) begin
          out_stall_i <= 1'b1;
          repeat (w) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && rx_hold_len == 0);
    end
  end

  // Compare each taken digest with the oldest expected one, word by word
  always @(posedge clk_i) begin : digest_check
    digest_t got;
    digest_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {hash_word_4_o, hash_word_3_o, hash_word_2_o, hash_word_1_o, hash_word_0_o};
      if (expected_digests.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: digest with none expected: %h", $realtime, got);
      end else begin
        want = expected_digests.pop_front();
        for (int j = 0; j < 5; j++) begin
          if (got[j] !== want[j]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: hash_word_%0d expected %h got %h",
                       $realtime, j, want[j], got[j]);
          end
        end
      end
    end
  end

  // Watchdog: a hung block shows up as a long run with no request taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty message, byte and end together, data extremes, requests with no byte
  task automatic test_directed();
    send_item(8'hA5, 1'b0, 1'b1);            // empty message
    send_item(8'h61, 1'b1, 1'b0);            // "abc", end on the last byte
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);            // no byte: ignored
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);            // end without a byte
    send_item(8'h00, 1'b1, 1'b1);            // one-byte message, zero byte
    send_item(8'hFF, 1'b1, 1'b1);            // one-byte message, all ones
    send_item(8'h5A, 1'b0, 1'b1);            // empty again, back to back
  endtask

  // No idling on either side: full-rate bytes, digests taken at once
  task automatic test_streaming();
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_message(64);
    send_message(0);
    send_message(56);
    send_message(200);
    send_message(3);
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
  endtask

  // Receiver holds off while the sender keeps going: a digest parks on the
  // outputs, the engine blocks on the next final block, the queue fills and
  // the input must stall.
  task automatic test_receiver_hold();
    tx_gap_max  = 0;
    rx_hold_len = RX_HOLD_CYCLES;
    for (int i = 0; i < 6; i++) send_message($urandom_range(10, 1));
    send_message(130);
    // idle the input while the hold runs out
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rx_hold_len != 0) @(posedge clk_i);
    tx_gap_max = GAP_MAX;
  endtask

  // Bulk of the run: random messages, lengths biased to block edges, and
  // occasional stretches with no idling on one or both sides
  task automatic test_random_messages();
    int sel;
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(99, 0);
      tx_gap_max = (sel < 15) ? 0 : GAP_MAX;
      rx_gap_max = (sel < 10 || sel >= 92) ? 0 : GAP_MAX;
      send_message(pick_len());
    end
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
  endtask

  initial begin
    sha1_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_streaming();
    test_receiver_hold();
    test_random_messages();
    in_valid_i <= 1'b0;

    // drain; the watchdog covers a digest that never comes
    while (expected_digests.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sha1_stream_hasher.f
src/sha1s_pkg.sv
src/sha1s_front.sv
src/sha1s_queue.sv
src/sha1s_back.sv
src/sha1_stream_hasher.sv
tb/testbench.sv
